// ===== hw/rtl/tms_pkg.sv =====
package tms_pkg;

	localparam int NUM_STATES_DEF = 16;
	localparam int TAPE_CELLS_DEF = 1024;
	localparam int NUM_SYMBOLS    = 256;

	localparam int SYM_W   = 8;
	localparam int STATE_W = 4;
	localparam int HEAD_W  = 10;

	localparam logic [SYM_W-1:0] BLANK_SYMBOL = 8'd66;

	localparam logic [1:0] CFG_START_STATE = 2'd0;
	localparam logic [1:0] CFG_END_STATE   = 2'd1;
	localparam logic [1:0] CFG_HEAD_START  = 2'd2;

	typedef enum logic [1:0] {
		ACT_LOAD_RULE = 2'd0,
		ACT_LOAD_TAPE = 2'd1,
		ACT_RESTART   = 2'd2,
		ACT_STEP      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_HALTED  = 2'd1,
		STAT_NO_RULE = 2'd2,
		STAT_EDGE    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TAPE,
		ST_RULE,
		ST_HOLD
	} fsm_t;

	typedef struct packed {
		logic               valid;
		logic [SYM_W-1:0]   wsym;
		logic               right;
		logic [STATE_W-1:0] next;
	} rule_t;

	typedef struct packed {
		logic [SYM_W-1:0]   sym;
		logic [HEAD_W-1:0]  head;
		logic [STATE_W-1:0] state;
		status_t            status;
	} result_t;

endpackage

// ===== hw/rtl/tms_ram.sv =====
module tms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/turing_machine_step.sv =====
// Single-tape Turing machine with a rule memory addressed by (state, symbol) and a tape memory.
// After reset the block clears both memories, one entry of each per cycle, over
// max(NUM_STATES*256, TAPE_CELLS) addresses (4096 by default) and accepts no word until done;
// configuration writes are taken throughout. A step does the tape read under the head, the
// dependent rule read, then the tape write (valid rule only) and result; a step that stops
// at the end state ends after the tape read. One item is in flight at a time, so the tape
// and rule memories never see overlapping accesses. The output register lets the next item
// be accepted while a result waits to be taken.
module turing_machine_step #(
	parameter int NUM_STATES = tms_pkg::NUM_STATES_DEF,
	parameter int TAPE_CELLS = tms_pkg::TAPE_CELLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// rule_state, match_symbol, write_symbol, move_right, next_state, cell_address, pad
	input  logic [39:0] s_axis_tdata,
	// action
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// machine_state, head_position, symbol_seen, pad
	output logic [23:0] m_axis_tdata,
	// status
	output logic [1:0]  m_axis_tuser
);

	import tms_pkg::*;

	localparam int SW        = $clog2(NUM_STATES);
	localparam int RULE_DEPTH = NUM_STATES * NUM_SYMBOLS;
	localparam int RAW       = $clog2(RULE_DEPTH);
	localparam int HW        = $clog2(TAPE_CELLS);
	localparam int CLR_DEPTH = (RULE_DEPTH > TAPE_CELLS) ? RULE_DEPTH : TAPE_CELLS;
	localparam int CW        = $clog2(CLR_DEPTH);

	fsm_t st_q, st_d;

	logic [STATE_W-1:0] start_q, end_q, state_q, state_d;
	logic [HEAD_W-1:0]  head_start_q;
	logic [HW-1:0]      head_q, head_d;
	logic               head_upd;
	logic [CW-1:0]      clr_q;
	logic [SYM_W-1:0]   sym_q;

	logic               in_acc;
	action_t            act;
	logic [STATE_W-1:0] in_rule_state, in_next;
	logic [SYM_W-1:0]   in_match, in_wsym;
	logic               in_right;
	logic [HEAD_W-1:0]  in_addr;

	logic               tape_we, tape_re;
	logic [HW-1:0]      tape_waddr;
	logic [SYM_W-1:0]   tape_wdata, tape_rdata;
	logic               rule_we, rule_re;
	logic [RAW-1:0]     rule_waddr, rule_raddr;
	rule_t              rule_wdata, rule_rdata;

	logic               fin, out_load;
	result_t            res_d, res_q, out_src;
	logic [HW-1:0]      head_sat, head_mv;
	logic               mv_edge;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign act           = action_t'(s_axis_tuser);
	assign in_rule_state = s_axis_tdata[3:0];
	assign in_match      = s_axis_tdata[11:4];
	assign in_wsym       = s_axis_tdata[19:12];
	assign in_right      = s_axis_tdata[20];
	assign in_next       = s_axis_tdata[24:21];
	assign in_addr       = s_axis_tdata[34:25];

	assign head_sat = (32'(head_start_q) < 32'(TAPE_CELLS)) ? HW'(head_start_q)
		: HW'(TAPE_CELLS - 1);

	always_comb begin
		head_mv = head_q;
		mv_edge = 1'b0;
		if (rule_rdata.right) begin
			if (32'(head_q) + 32'd1 < 32'(TAPE_CELLS)) begin
				head_mv = head_q + HW'(1);
			end else begin
				mv_edge = 1'b1;
			end
		end else begin
			if (head_q != '0) begin
				head_mv = head_q - HW'(1);
			end else begin
				mv_edge = 1'b1;
			end
		end
	end

	always_comb begin
		st_d       = st_q;
		fin        = 1'b0;
		res_d      = '{sym: '0, head: HEAD_W'(head_q), state: state_q, status: STAT_OK};
		state_d    = state_q;
		head_d     = head_q;
		head_upd   = 1'b0;
		tape_we    = 1'b0;
		tape_waddr = head_q;
		tape_wdata = rule_rdata.wsym;
		tape_re    = 1'b0;
		rule_we    = 1'b0;
		rule_waddr = {SW'(in_rule_state), in_match};
		rule_wdata = '{valid: 1'b1, wsym: in_wsym, right: in_right, next: in_next};
		rule_re    = 1'b0;
		rule_raddr = {SW'(state_q), tape_rdata};
		case (st_q)
			ST_CLEAR: begin
				tape_we    = (32'(clr_q) < 32'(TAPE_CELLS));
				tape_waddr = clr_q[HW-1:0];
				tape_wdata = BLANK_SYMBOL;
				rule_we    = (32'(clr_q) < 32'(RULE_DEPTH));
				rule_waddr = clr_q[RAW-1:0];
				rule_wdata = '0;
				if (clr_q == CW'(CLR_DEPTH - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					case (act)
						ACT_LOAD_RULE: begin
							rule_we = (32'(in_rule_state) < 32'(NUM_STATES));
							fin     = 1'b1;
						end
						ACT_LOAD_TAPE: begin
							tape_we    = (32'(in_addr) < 32'(TAPE_CELLS));
							tape_waddr = HW'(in_addr);
							tape_wdata = in_match;
							fin        = 1'b1;
						end
						ACT_RESTART: begin
							state_d     = start_q;
							head_d      = head_sat;
							head_upd    = 1'b1;
							res_d.state = start_q;
							res_d.head  = HEAD_W'(head_sat);
							fin         = 1'b1;
						end
						ACT_STEP: begin
							tape_re = 1'b1;
							st_d    = ST_TAPE;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_TAPE: begin
				res_d.sym = tape_rdata;
				if (state_q == end_q) begin
					res_d.status = STAT_HALTED;
					fin          = 1'b1;
				end else if (32'(state_q) >= 32'(NUM_STATES)) begin
					res_d.status = STAT_NO_RULE;
					fin          = 1'b1;
				end else begin
					rule_re = 1'b1;
					st_d    = ST_RULE;
				end
			end
			ST_RULE: begin
				res_d.sym = sym_q;
				fin       = 1'b1;
				if (!rule_rdata.valid) begin
					res_d.status = STAT_NO_RULE;
				end else begin
					tape_we      = 1'b1;
					state_d      = rule_rdata.next;
					head_d       = head_mv;
					head_upd     = 1'b1;
					res_d.state  = rule_rdata.next;
					res_d.head   = HEAD_W'(head_mv);
					res_d.status = mv_edge ? STAT_EDGE : STAT_OK;
				end
			end
			ST_HOLD: begin
				if (out_load) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			st_d = out_load ? ST_IDLE : ST_HOLD;
		end
	end

	assign out_src  = (st_q == ST_HOLD) ? res_q : res_d;
	assign out_load = (fin || (st_q == ST_HOLD)) && (!m_axis_tvalid || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			state_q      <= '0;
			head_q       <= '0;
			start_q      <= '0;
			end_q        <= 4'd15;
			head_start_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end
			state_q <= state_d;
			if (head_upd) begin
				head_q <= head_d;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_STATE: start_q      <= cfg_data[STATE_W-1:0];
					CFG_END_STATE:   end_q        <= cfg_data[STATE_W-1:0];
					CFG_HEAD_START:  head_start_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_TAPE) begin
			sym_q <= tape_rdata;
		end
		if (fin) begin
			res_q <= res_d;
		end
		if (out_load) begin
			m_axis_tdata <= {2'b00, out_src.sym, out_src.head, out_src.state};
			m_axis_tuser <= out_src.status;
		end
	end

	tms_ram #(
		.WIDTH(SYM_W),
		.DEPTH(TAPE_CELLS)
	) u_tape (
		.clk  (clk),
		.we   (tape_we),
		.waddr(tape_waddr),
		.wdata(tape_wdata),
		.re   (tape_re),
		.raddr(head_q),
		.rdata(tape_rdata)
	);

	tms_ram #(
		.WIDTH($bits(rule_t)),
		.DEPTH(RULE_DEPTH)
	) u_rule (
		.clk  (clk),
		.we   (rule_we),
		.waddr(rule_waddr),
		.wdata(rule_wdata),
		.re   (rule_re),
		.raddr(rule_raddr),
		.rdata(rule_rdata)
	);

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < 32'(TAPE_CELLS))
		else $error("head outside tape");

	a_tape_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(tape_we && tape_re))
		else $error("tape read and write in one cycle");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (act == ACT_STEP)) |=> !s_axis_tready)
		else $error("word accepted while a step is in flight");

	a_no_rule_read_halted: assert property (@(posedge clk) disable iff (!arst_n)
		rule_re |-> (state_q != end_q))
		else $error("rule read in end state");

endmodule
